>>> design/cce_pkg.sv
// shared types, codes and constants of the coordinate command engine
package cce_pkg;

  // bus widths
  localparam int DataW   = 144;
  localparam int UserInW = 10;
  localparam int UserOutW = 3;
  localparam int CfgIdxW = 3;

  // command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // feed scaling: feed * 10^9 / 582108237, done as reciprocal plus one correction
  localparam longint unsigned FeedNum   = 64'd1000000000;
  localparam longint unsigned FeedDen   = 64'd582108237;
  localparam int              FeedShift = 31;
  localparam longint unsigned FeedRecip = ((64'd1 << FeedShift) * FeedNum) / FeedDen;

  // register reset values
  localparam logic [31:0] StepsMmReset   = 32'd6553600;
  localparam logic [31:0] StepsInchReset = 32'd166461440;
  localparam logic [30:0] RapidReset     = 31'd6553600;

  // saturation bounds
  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_X_MM   = 3'd0,
    CFG_Y_MM   = 3'd1,
    CFG_Z_MM   = 3'd2,
    CFG_X_INCH = 3'd3,
    CFG_Y_INCH = 3'd4,
    CFG_Z_INCH = 3'd5,
    CFG_RAPID  = 3'd6
  } cfg_idx_t;

  // incoming command codes
  typedef enum logic [4:0] {
    CMD_G00 = 5'd0,
    CMD_G01 = 5'd1,
    CMD_G10 = 5'd2,
    CMD_G11 = 5'd3,
    CMD_G20 = 5'd4,
    CMD_G21 = 5'd5,
    CMD_G28 = 5'd6,
    CMD_G29 = 5'd7,
    CMD_G90 = 5'd8,
    CMD_G91 = 5'd9,
    CMD_G92 = 5'd10,
    CMD_END = 5'd11,
    CMD_M03 = 5'd12,
    CMD_M05 = 5'd13,
    CMD_M17 = 5'd14,
    CMD_M18 = 5'd15,
    CMD_NOP = 5'd16
  } cmd_t;

  // classified operations carried through the queue
  typedef enum logic [3:0] {
    OP_RAPID,
    OP_LINEAR,
    OP_HOME_G28,
    OP_HOME_G29,
    OP_SET_OFF,
    OP_CLR_OFF,
    OP_TEACH_OFF,
    OP_INCH,
    OP_MM,
    OP_ABS,
    OP_REL,
    OP_RESULT
  } op_t;

  // result kinds
  typedef enum logic [UserOutW-1:0] {
    ACT_MOVE     = 3'd0,
    ACT_FEED     = 3'd1,
    ACT_SPINDLE  = 3'd2,
    ACT_HOME     = 3'd3,
    ACT_STEP_ON  = 3'd4,
    ACT_STEP_OFF = 3'd5,
    ACT_END      = 3'd6
  } action_t;

  // result list bits, emitted lowest first
  localparam int ResPreHome  = 0;
  localparam int ResFeed     = 1;
  localparam int ResMove     = 2;
  localparam int ResPostHome = 3;
  localparam int ResSingle   = 4;
  localparam int ResW        = 5;

  // classified command
  typedef struct packed {
    op_t              op;
    action_t          action;
    logic [2:0][31:0] val;
    logic [2:0]       has;
    logic [30:0]      feed;
    logic             feed_keep;
    logic [15:0]      spindle;
  } item_t;

  // executed command handed to the arithmetic pipeline
  typedef struct packed {
    logic [ResW-1:0]  mask;
    action_t          action;
    logic [2:0][31:0] d;
    logic [2:0][31:0] k;
    logic [30:0]      feed;
    logic [15:0]      spindle;
  } pkt_t;

  // finished command waiting for output
  typedef struct packed {
    logic [ResW-1:0]  mask;
    action_t          action;
    logic [2:0][31:0] steps;
    logic [31:0]      feed_rate;
    logic [15:0]      spindle;
  } res_t;

  // configuration registers
  typedef struct packed {
    logic [2:0][31:0] steps_mm;
    logic [2:0][31:0] steps_inch;
    logic [30:0]      rapid_feed;
  } cfg_t;

endpackage

>>> design/cce_front.sv
// front: classifies an incoming command beat into a queue item
module cce_front (
  input  logic [cce_pkg::DataW-1:0]   s_axis_tdata,
  input  logic [cce_pkg::UserInW-1:0] s_axis_tuser,
  input  logic [30:0]                 rapid_feed,
  output cce_pkg::item_t              item,
  output logic                        keep
);

  logic has_feed;
  logic has_spindle;

  // field unpacking and command decode
  always_comb begin
    has_feed    = s_axis_tuser[8];
    has_spindle = s_axis_tuser[9];
    item        = '0;
    item.val[0] = s_axis_tdata[31:0];
    item.val[1] = s_axis_tdata[63:32];
    item.val[2] = s_axis_tdata[95:64];
    item.has    = s_axis_tuser[7:5];
    item.feed   = rapid_feed;
    item.op     = cce_pkg::OP_RESULT;
    item.action = cce_pkg::ACT_END;
    keep        = 1'b1;
    unique case (cce_pkg::cmd_t'(s_axis_tuser[4:0]))
      cce_pkg::CMD_G00: item.op = cce_pkg::OP_RAPID;
      cce_pkg::CMD_G01: begin
        item.op        = cce_pkg::OP_LINEAR;
        item.feed      = has_feed ? s_axis_tdata[126:96] : '0;
        item.feed_keep = !has_feed;
      end
      cce_pkg::CMD_G10: item.op = cce_pkg::OP_SET_OFF;
      cce_pkg::CMD_G11: item.op = cce_pkg::OP_CLR_OFF;
      cce_pkg::CMD_G20: item.op = cce_pkg::OP_INCH;
      cce_pkg::CMD_G21: item.op = cce_pkg::OP_MM;
      cce_pkg::CMD_G28: item.op = cce_pkg::OP_HOME_G28;
      cce_pkg::CMD_G29: item.op = cce_pkg::OP_HOME_G29;
      cce_pkg::CMD_G90: item.op = cce_pkg::OP_ABS;
      cce_pkg::CMD_G91: item.op = cce_pkg::OP_REL;
      cce_pkg::CMD_G92: item.op = cce_pkg::OP_TEACH_OFF;
      cce_pkg::CMD_END: item.action = cce_pkg::ACT_END;
      cce_pkg::CMD_M03: begin
        item.action  = cce_pkg::ACT_SPINDLE;
        item.spindle = s_axis_tdata[142:127];
        keep         = has_spindle;
      end
      cce_pkg::CMD_M05: item.action = cce_pkg::ACT_SPINDLE;
      cce_pkg::CMD_M17: item.action = cce_pkg::ACT_STEP_ON;
      cce_pkg::CMD_M18: item.action = cce_pkg::ACT_STEP_OFF;
      cce_pkg::CMD_NOP: keep = 1'b0;
      default:          keep = 1'b0;
    endcase
  end

endmodule

>>> design/cce_queue.sv
// short command queue between front and back
module cce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cce_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output cce_pkg::item_t head_item
);

  cce_pkg::item_t                  mem [cce_pkg::QDepth];
  logic [cce_pkg::QPtrW-1:0]       wptr;
  logic [cce_pkg::QPtrW-1:0]       rptr;
  logic [cce_pkg::QCntW-1:0]       count;

  assign full       = (count == cce_pkg::QCntW'(cce_pkg::QDepth));
  assign head_valid = (count != '0);
  assign head_item  = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == cce_pkg::QPtrW'(cce_pkg::QDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == cce_pkg::QPtrW'(cce_pkg::QDepth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

>>> design/cce_exec.sv
// back, first part: modal state, position and offsets, move deltas
module cce_exec (
  input  logic           clk,
  input  logic           rst,
  input  cce_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  cce_pkg::item_t q_item,
  output logic           q_pop,
  output logic           pkt_valid,
  input  logic           pkt_ready,
  output cce_pkg::pkt_t  pkt
);

  logic             absolute_mode;
  logic             inch_mode;
  logic [2:0][31:0] pos;
  logic [2:0][31:0] work_off;
  logic [30:0]      current_feed;
  logic             pend_valid;

  logic             abs_m;
  logic [2:0][31:0] delta;
  logic [2:0][31:0] teach;
  logic [2:0][31:0] pos_next;
  logic [30:0]      feed_sel;
  logic             feed_chg;
  logic             is_move;
  cce_pkg::pkt_t    pkt_next;

  function automatic logic [33:0] ext34(input logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] r;
    priority if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = cce_pkg::SatMin;
    end else begin
      r = cce_pkg::SatMax;
    end
    return r;
  endfunction

  assign q_pop     = q_valid && !pend_valid;
  assign pkt_valid = pend_valid;

  // deltas, offsets and feed choice for the queue head
  always_comb begin
    abs_m = absolute_mode || q_item.op == cce_pkg::OP_HOME_G28 ||
            q_item.op == cce_pkg::OP_HOME_G29;
    for (int i = 0; i < 3; i++) begin
      if (!q_item.has[i]) begin
        delta[i] = '0;
      end else if (abs_m) begin
        delta[i] = sat34(ext34(q_item.val[i]) - ext34(pos[i]) + ext34(work_off[i]));
      end else begin
        delta[i] = q_item.val[i];
      end
      teach[i]    = sat34(ext34(pos[i]) - ext34(q_item.val[i]));
      pos_next[i] = sat34(ext34(pos[i]) + ext34(pkt.d[i]));
    end
    feed_sel = q_item.feed_keep ? current_feed : q_item.feed;
    feed_chg = (feed_sel != current_feed) && (feed_sel != '0);
    is_move  = q_item.op == cce_pkg::OP_RAPID || q_item.op == cce_pkg::OP_LINEAR ||
               q_item.op == cce_pkg::OP_HOME_G28 || q_item.op == cce_pkg::OP_HOME_G29;
  end

  // result list and operands for the arithmetic pipeline
  always_comb begin
    pkt_next         = '0;
    pkt_next.action  = q_item.action;
    pkt_next.feed    = feed_sel;
    pkt_next.spindle = q_item.spindle;
    pkt_next.k       = inch_mode ? cfg.steps_inch : cfg.steps_mm;
    if (is_move) begin
      pkt_next.d                     = delta;
      pkt_next.mask[cce_pkg::ResMove] = 1'b1;
      pkt_next.mask[cce_pkg::ResFeed] = feed_chg;
      pkt_next.mask[cce_pkg::ResPreHome]  = q_item.op == cce_pkg::OP_HOME_G29;
      pkt_next.mask[cce_pkg::ResPostHome] = q_item.op == cce_pkg::OP_HOME_G28;
    end else begin
      pkt_next.mask[cce_pkg::ResSingle] = 1'b1;
    end
  end

  // modal and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      absolute_mode <= 1'b1;
      inch_mode     <= 1'b0;
      pos           <= '0;
      work_off      <= '0;
      current_feed  <= '0;
      pend_valid    <= 1'b0;
    end else begin
      // position follows once the packet leaves
      if (pend_valid && pkt_ready) begin
        pos        <= pos_next;
        pend_valid <= 1'b0;
      end
      if (q_pop) begin
        unique case (q_item.op)
          cce_pkg::OP_RAPID, cce_pkg::OP_LINEAR,
          cce_pkg::OP_HOME_G28, cce_pkg::OP_HOME_G29: begin
            pend_valid <= 1'b1;
            if (feed_chg) begin
              current_feed <= feed_sel;
            end
          end
          cce_pkg::OP_RESULT: pend_valid <= 1'b1;
          cce_pkg::OP_SET_OFF: begin
            for (int i = 0; i < 3; i++) begin
              if (q_item.has[i]) begin
                work_off[i] <= q_item.val[i];
              end
            end
          end
          cce_pkg::OP_CLR_OFF: work_off <= '0;
          cce_pkg::OP_TEACH_OFF: begin
            for (int i = 0; i < 3; i++) begin
              if (q_item.has[i]) begin
                work_off[i] <= teach[i];
              end
            end
          end
          cce_pkg::OP_INCH: inch_mode     <= 1'b1;
          cce_pkg::OP_MM:   inch_mode     <= 1'b0;
          cce_pkg::OP_ABS:  absolute_mode <= 1'b1;
          cce_pkg::OP_REL:  absolute_mode <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  // packet register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      pkt <= pkt_next;
    end
  end

endmodule

>>> design/cce_arith.sv
// back, second part: step scaling and feed conversion over three stages
module cce_arith #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cce_pkg::pkt_t in_pkt,
  output logic          out_valid,
  input  logic          out_ready,
  output cce_pkg::res_t out_res
);

  // stage 1: magnitudes and feed products
  logic                    v1;
  logic [cce_pkg::ResW-1:0] mask1;
  cce_pkg::action_t        action1;
  logic [15:0]             spindle1;
  logic [2:0][31:0]        mag1;
  logic [2:0]              neg1;
  logic [2:0][31:0]        k1;
  logic [62:0]             pf1;
  logic [60:0]             pf2_1;

  // stage 2: step products and quotient check product
  logic                    v2;
  logic [cce_pkg::ResW-1:0] mask2;
  cce_pkg::action_t        action2;
  logic [15:0]             spindle2;
  logic [2:0]              neg2;
  logic [2:0][63:0]        pm2;
  logic [31:0]             qe2;
  logic [61:0]             qd2;
  logic [60:0]             pf2_2;

  logic                    r1;
  logic                    r2;
  logic                    r3;
  logic [2:0][63:0]        q3;
  logic [2:0][31:0]        steps3;
  logic [61:0]             rem3;
  logic [31:0]             feed3;

  assign r3       = !out_valid || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) out_valid <= v2;
    end
  end

  // stage 1 data
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      mask1    <= in_pkt.mask;
      action1  <= in_pkt.action;
      spindle1 <= in_pkt.spindle;
      k1       <= in_pkt.k;
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_pkt.d[i][31];
        mag1[i] <= in_pkt.d[i][31] ? 32'(-in_pkt.d[i]) : in_pkt.d[i];
      end
      pf1   <= 63'(in_pkt.feed) * 63'(cce_pkg::FeedRecip);
      pf2_1 <= 61'(in_pkt.feed) * 61'(cce_pkg::FeedNum);
    end
  end

  // stage 2 data
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      mask2    <= mask1;
      action2  <= action1;
      spindle2 <= spindle1;
      neg2     <= neg1;
      for (int i = 0; i < 3; i++) begin
        pm2[i] <= 64'(mag1[i]) * 64'(k1[i]);
      end
      qe2   <= pf1[62:cce_pkg::FeedShift];
      qd2   <= 62'(pf1[62:cce_pkg::FeedShift]) * 62'(cce_pkg::FeedDen);
      pf2_2 <= pf2_1;
    end
  end

  // truncation, saturation and quotient correction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q3[i] = pm2[i] >> (2 * FRAC_BITS);
      if (|q3[i][63:31]) begin
        steps3[i] = neg2[i] ? cce_pkg::SatMin : cce_pkg::SatMax;
      end else begin
        steps3[i] = neg2[i] ? 32'(-q3[i][31:0]) : q3[i][31:0];
      end
    end
    rem3  = {1'b0, pf2_2} - qd2;
    feed3 = qe2 + 32'(rem3 >= 62'(cce_pkg::FeedDen));
  end

  // stage 3 data
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      out_res.mask      <= mask2;
      out_res.action    <= action2;
      out_res.spindle   <= spindle2;
      out_res.steps     <= steps3;
      out_res.feed_rate <= feed3;
    end
  end

endmodule

>>> design/cce_emit.sv
// back, last part: walks the result list of a command onto the output register
module cce_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cce_pkg::res_t                 in_res,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cce_pkg::DataW-1:0]     m_axis_tdata,
  output logic [cce_pkg::UserOutW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);

  logic [cce_pkg::ResW-1:0] cur_mask;
  cce_pkg::res_t            cur;
  logic                     out_load;
  logic [cce_pkg::ResW-1:0] first;
  logic [cce_pkg::ResW-1:0] rest;
  cce_pkg::action_t         act;
  logic [cce_pkg::DataW-1:0] data;

  // pick the next pending result
  always_comb begin
    out_load = !m_axis_tvalid || m_axis_tready;
    first    = cur_mask & cce_pkg::ResW'(~cur_mask + 1'b1);
    rest     = cur_mask & ~first;
    in_ready = (cur_mask == '0) || (out_load && rest == '0);
    data     = '0;
    priority if (first[cce_pkg::ResPreHome]) begin
      act = cce_pkg::ACT_HOME;
    end else if (first[cce_pkg::ResFeed]) begin
      act          = cce_pkg::ACT_FEED;
      data[127:96] = cur.feed_rate;
    end else if (first[cce_pkg::ResMove]) begin
      act         = cce_pkg::ACT_MOVE;
      data[95:0]  = cur.steps;
    end else if (first[cce_pkg::ResPostHome]) begin
      act = cce_pkg::ACT_HOME;
    end else begin
      act            = cur.action;
      data[143:128]  = cur.spindle;
    end
  end

  // result list and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      cur_mask      <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= |cur_mask;
      end
      // a new command only enters once the list is empty or on its last beat
      if (in_valid && in_ready) begin
        cur_mask <= in_res.mask;
      end else if (out_load && |cur_mask) begin
        cur_mask <= rest;
      end
    end
  end

  // output beat and held command
  always_ff @(posedge clk) begin
    if (out_load && |cur_mask) begin
      m_axis_tdata <= data;
      m_axis_tuser <= act;
      m_axis_tlast <= (rest == '0);
    end
    if (in_valid && in_ready) begin
      cur <= in_res;
    end
  end

endmodule

>>> design/cnc_coordinate_command_engine_top.sv
// top level of the coordinate command engine
//
// One pre-decoded command per input beat; each command gives zero to three result
// beats, three at most for a homing move with a feed change. Commands are
// classified on entry and wait in a four-deep queue, so the input keeps taking
// beats while the back end works. The back end works out the delta of a command
// that produces results and updates the position once its packet is taken; a
// mode or offset command only changes the modal state or the offsets. Each result
// then has its own output beat. The first result of a command passes, after it
// leaves the queue, through the delta register, the three arithmetic stages that
// scale steps and convert the feed, the result list register and the output
// register. Configuration writes are always taken (cfg_ready stays high) and must
// be made while no command is in flight.
module cnc_coordinate_command_engine_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // command input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // x_value[31:0], y_value[63:32], z_value[95:64], feed_value[126:96],
  // spindle_value[142:127], zero pad[143]
  input  logic [cce_pkg::DataW-1:0]     s_axis_tdata,
  // cmd[4:0], has_x[5], has_y[6], has_z[7], has_feed[8], has_spindle[9]
  input  logic [cce_pkg::UserInW-1:0]   s_axis_tuser,
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // step_x[31:0], step_y[63:32], step_z[95:64], feed_rate[127:96],
  // spindle_speed[143:128]
  output logic [cce_pkg::DataW-1:0]     m_axis_tdata,
  // action[2:0]
  output logic [cce_pkg::UserOutW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cce_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data
);

  cce_pkg::cfg_t  cfg;
  cce_pkg::item_t fe_item;
  logic           fe_keep;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  cce_pkg::item_t q_item;
  logic           ex_valid;
  logic           ex_ready;
  cce_pkg::pkt_t  ex_pkt;
  logic           ar_valid;
  logic           ar_ready;
  cce_pkg::res_t  ar_res;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready && fe_keep;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_mm   <= {3{cce_pkg::StepsMmReset}};
      cfg.steps_inch <= {3{cce_pkg::StepsInchReset}};
      cfg.rapid_feed <= cce_pkg::RapidReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cce_pkg::cfg_idx_t'(cfg_index))
        cce_pkg::CFG_X_MM:   cfg.steps_mm[0]   <= cfg_data;
        cce_pkg::CFG_Y_MM:   cfg.steps_mm[1]   <= cfg_data;
        cce_pkg::CFG_Z_MM:   cfg.steps_mm[2]   <= cfg_data;
        cce_pkg::CFG_X_INCH: cfg.steps_inch[0] <= cfg_data;
        cce_pkg::CFG_Y_INCH: cfg.steps_inch[1] <= cfg_data;
        cce_pkg::CFG_Z_INCH: cfg.steps_inch[2] <= cfg_data;
        cce_pkg::CFG_RAPID:  cfg.rapid_feed    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  cce_front u_front (
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .rapid_feed   (cfg.rapid_feed),
    .item         (fe_item),
    .keep         (fe_keep)
  );

  cce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (fe_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  cce_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pkt_valid (ex_valid),
    .pkt_ready (ex_ready),
    .pkt       (ex_pkt)
  );

  cce_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_pkt    (ex_pkt),
    .out_valid (ar_valid),
    .out_ready (ar_ready),
    .out_res   (ar_res)
  );

  cce_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (ar_valid),
    .in_ready      (ar_ready),
    .in_res        (ar_res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // every executed packet is either one move or one single result
  a_move_or_single: assert property (@(posedge clk) disable iff (rst)
    ex_valid |-> ex_pkt.mask[cce_pkg::ResSingle] != ex_pkt.mask[cce_pkg::ResMove])
    else $error("packet is not exactly one of move or single result");

  // a homing move reports the home surface once
  a_home_once: assert property (@(posedge clk) disable iff (rst)
    ex_valid |-> !(ex_pkt.mask[cce_pkg::ResPreHome] && ex_pkt.mask[cce_pkg::ResPostHome]))
    else $error("homing packet with home surface on both sides");

  // a feed change beat carries no steps and no spindle speed
  a_feed_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == cce_pkg::ACT_FEED |->
      m_axis_tdata[95:0] == '0 && m_axis_tdata[143:128] == '0)
    else $error("feed beat carries step or spindle data");
`endif

endmodule

>>> tb/tb.sv
// self-checking testbench of the coordinate command engine: table and random commands
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cce_pkg::*;

  localparam int FracBits    = 16;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;
  localparam int DirRows     = 27;

  // codes with no meaning, unused register index
  localparam logic [4:0] CodeFirstUnused = 5'd17;
  localparam logic [4:0] CodeTop         = 5'd31;
  localparam logic [2:0] CfgUnused       = 3'd7;

  localparam logic [31:0] SatHi = 32'h7fff_ffff;
  localparam logic [31:0] SatLo = 32'h8000_0000;
  localparam logic [95:0] NoAxes = 96'd0;

  // feed scaling: feed divided by 0.00970180395 times sixty
  localparam longint unsigned FeedScaleNum = 64'd1000000000;
  localparam longint unsigned FeedScaleDen = 64'd582108237;

  typedef enum {SET_LOW, SET_HIGH, SET_RANDOM} setup_style_t;

  // one decoded command, axis fields x in the lowest slot
  typedef struct packed {
    logic [4:0]       code;
    logic [2:0][31:0] val;
    logic [2:0]       has;
    logic [30:0]      feed;
    logic             has_feed;
    logic [15:0]      spindle;
    logic             has_spindle;
  } cmd_beat_t;

  // one machine action
  typedef struct packed {
    action_t     act;
    logic [31:0] step_x;
    logic [31:0] step_y;
    logic [31:0] step_z;
    logic [31:0] rate;
    logic [15:0] spd;
    logic        last;
  } motion_result_t;

  // directed row: typed rows give their single action directly
  typedef struct packed {
    cmd_beat_t   b;
    logic        typed;
    action_t     t_act;
    logic [15:0] t_spd;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;
  logic [UserInW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;
  logic [UserOutW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [31:0]         cfg_data;

  // shadow registers and machine state
  logic [31:0] k_mm [3];
  logic [31:0] k_inch [3];
  logic [30:0] rapid_feed;
  logic        abs_coords;
  logic        inch_mode;
  longint      pos [3];
  longint      work_off [3];
  logic [31:0] current_feed;

  motion_result_t plan [$];
  motion_result_t queued_actions [$];
  motion_result_t want;
  int             mismatches = 0;
  bit             calm;
  bit             hold_ask;

  dir_row_t directed_rows [DirRows] = '{
    '{'{CMD_M17, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b1, ACT_STEP_ON, 16'd0},
    '{'{CMD_M03, NoAxes, 3'b000, 31'd0, 1'b0, 16'd65535, 1'b1}, 1'b1, ACT_SPINDLE, 16'd65535},
    // spindle on without a speed word
    '{'{CMD_M03, NoAxes, 3'b000, 31'd0, 1'b0, 16'd1234, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_M05, NoAxes, 3'b000, 31'd0, 1'b0, 16'd77, 1'b1}, 1'b1, ACT_SPINDLE, 16'd0},
    '{'{CMD_G01, {32'd0, 32'd0, 32'h0001_0000}, 3'b001, 31'd6553600, 1'b1, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    // zero feed word keeps the current feed silently
    '{'{CMD_G01, {32'h0000_8000, 32'd0, 32'd0}, 3'b100, 31'd0, 1'b1, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G01, {32'd0, 32'd0, 32'h0002_0000}, 3'b001, 31'h7fff_ffff, 1'b1, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G00, {SatHi, SatHi, SatHi}, 3'b111, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G00, {SatLo, SatLo, SatLo}, 3'b111, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G91, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G01, {32'd0, 32'h0003_0000, 32'hfffe_8000}, 3'b011, 31'd0, 1'b0, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G20, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G01, {32'd0, 32'h0001_0000, 32'd0}, 3'b010, 31'd0, 1'b0, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G21, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G10, {32'd0, 32'hfff6_0000, 32'h000a_0000}, 3'b111, 31'd0, 1'b0, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G90, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G00, NoAxes, 3'b111, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G92, {32'd0, SatLo, SatHi}, 3'b111, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G11, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G91, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b0, ACT_MOVE, 16'd0},
    // homing moves run absolute even in relative mode
    '{'{CMD_G28, {32'hfffb_0000, 32'd0, 32'h0005_0000}, 3'b101, 31'd0, 1'b0, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_G29, {32'd0, 32'h0001_0000, 32'd0}, 3'b010, 31'd0, 1'b0, 16'd0, 1'b0},
      1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_NOP, NoAxes, 3'b111, 31'd0, 1'b1, 16'd0, 1'b1}, 1'b0, ACT_MOVE, 16'd0},
    // code with no meaning
    '{'{CodeTop, NoAxes, 3'b111, 31'd0, 1'b1, 16'd0, 1'b1}, 1'b0, ACT_MOVE, 16'd0},
    '{'{CMD_END, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b1, ACT_END, 16'd0},
    '{'{CMD_M18, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b0}, 1'b1, ACT_STEP_OFF, 16'd0},
    '{'{CMD_M03, NoAxes, 3'b000, 31'd0, 1'b0, 16'd0, 1'b1}, 1'b1, ACT_SPINDLE, 16'd0}
  };

  cnc_coordinate_command_engine_top #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint wide(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // distance times steps per unit, truncated toward zero and saturated
  function automatic logic [31:0] to_steps(longint d, logic [31:0] k);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (mag * {32'd0, k}) >> (2 * FracBits);
    if (d < 0) return (q >= 64'h8000_0000) ? SatLo : 32'(64'd0 - q);
    return (q > 64'h7fff_ffff) ? SatHi : q[31:0];
  endfunction

  function automatic motion_result_t beat_of(action_t act, logic [15:0] spd, logic [31:0] rate);
    motion_result_t r;
    r = '0;
    r.act = act;
    r.spd = spd;
    r.rate = rate;
    return r;
  endfunction

  // feed change if any, then the step beat; position updates with saturation
  function automatic void plan_move(cmd_beat_t b, bit rapid, bit force_abs);
    longint           d [3];
    logic [30:0]      f;
    logic [63:0]      scaled;
    motion_result_t   r;
    for (int a = 0; a < 3; a++) begin
      d[a] = 0;
      if (b.has[a]) begin
        d[a] = (force_abs || abs_coords) ? sat32(wide(b.val[a]) - pos[a] + work_off[a])
                                         : wide(b.val[a]);
      end
      pos[a] = sat32(pos[a] + d[a]);
    end
    if (rapid) f = rapid_feed;
    else if (b.has_feed) f = b.feed;
    else f = current_feed[30:0];
    if ({1'b0, f} != current_feed && f != 31'd0) begin
      scaled = ({33'd0, f} * FeedScaleNum) / FeedScaleDen;
      plan.push_back(beat_of(ACT_FEED, 16'd0, scaled[31:0]));
      current_feed = {1'b0, f};
    end
    r = beat_of(ACT_MOVE, 16'd0, 32'd0);
    r.step_x = to_steps(d[0], inch_mode ? k_inch[0] : k_mm[0]);
    r.step_y = to_steps(d[1], inch_mode ? k_inch[1] : k_mm[1]);
    r.step_z = to_steps(d[2], inch_mode ? k_inch[2] : k_mm[2]);
    plan.push_back(r);
  endfunction

  // machine behavior for one command, actions collected in plan
  function automatic void interpret_command(cmd_beat_t b);
    plan.delete();
    case (b.code)
      CMD_G00: plan_move(b, 1'b1, 1'b0);
      CMD_G01: plan_move(b, 1'b0, 1'b0);
      CMD_G10: begin
        for (int a = 0; a < 3; a++) if (b.has[a]) work_off[a] = wide(b.val[a]);
      end
      CMD_G11: begin
        for (int a = 0; a < 3; a++) work_off[a] = 0;
      end
      CMD_G20: inch_mode = 1'b1;
      CMD_G21: inch_mode = 1'b0;
      CMD_G28: begin
        plan_move(b, 1'b1, 1'b1);
        plan.push_back(beat_of(ACT_HOME, 16'd0, 32'd0));
      end
      CMD_G29: begin
        plan.push_back(beat_of(ACT_HOME, 16'd0, 32'd0));
        plan_move(b, 1'b1, 1'b1);
      end
      CMD_G90: abs_coords = 1'b1;
      CMD_G91: abs_coords = 1'b0;
      CMD_G92: begin
        for (int a = 0; a < 3; a++) if (b.has[a]) work_off[a] = sat32(pos[a] - wide(b.val[a]));
      end
      CMD_END: plan.push_back(beat_of(ACT_END, 16'd0, 32'd0));
      CMD_M03: if (b.has_spindle) plan.push_back(beat_of(ACT_SPINDLE, b.spindle, 32'd0));
      CMD_M05: plan.push_back(beat_of(ACT_SPINDLE, 16'd0, 32'd0));
      CMD_M17: plan.push_back(beat_of(ACT_STEP_ON, 16'd0, 32'd0));
      CMD_M18: plan.push_back(beat_of(ACT_STEP_OFF, 16'd0, 32'd0));
      default: ;
    endcase
  endfunction

  // mark the final beat of the command and queue them all
  function automatic void commit_plan();
    if (plan.size() != 0) plan[plan.size() - 1].last = 1'b1;
    foreach (plan[i]) queued_actions.push_back(plan[i]);
    plan.delete();
  endfunction

  function automatic logic [31:0] random_axis();
    case ($urandom_range(0, 9))
      0: return SatHi;
      1: return SatLo;
      2, 3: return $urandom();
      default: return 32'($urandom_range(0, 32'h00ff_ffff)) - 32'h0080_0000;
    endcase
  endfunction

  // mostly moves, with modes, offsets and machine commands mixed in
  function automatic cmd_beat_t random_command();
    cmd_beat_t b;
    int        pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) b.code = CMD_G01;
    else if (pick < 40) b.code = CMD_G00;
    else if (pick < 48) b.code = CMD_G28;
    else if (pick < 56) b.code = CMD_G29;
    else if (pick < 60) b.code = CMD_G90;
    else if (pick < 64) b.code = CMD_G91;
    else if (pick < 67) b.code = CMD_G20;
    else if (pick < 70) b.code = CMD_G21;
    else if (pick < 73) b.code = CMD_G10;
    else if (pick < 76) b.code = CMD_G11;
    else if (pick < 79) b.code = CMD_G92;
    else if (pick < 82) b.code = CMD_M03;
    else if (pick < 85) b.code = CMD_M05;
    else if (pick < 88) b.code = CMD_M17;
    else if (pick < 91) b.code = CMD_M18;
    else if (pick < 93) b.code = CMD_END;
    else if (pick < 95) b.code = CMD_NOP;
    else b.code = 5'($urandom_range(CodeFirstUnused, CodeTop));
    for (int a = 0; a < 3; a++) b.val[a] = random_axis();
    b.has = 3'($urandom()) | 3'($urandom());
    // a small pool of feeds so that repeats leave the feed unchanged
    case ($urandom_range(0, 7))
      0: b.feed = 31'd0;
      1: b.feed = 31'h7fff_ffff;
      2, 3: b.feed = 31'($urandom());
      4: b.feed = 31'd1638400;
      5: b.feed = 31'd3276800;
      default: b.feed = 31'd6553600;
    endcase
    b.has_feed = 1'($urandom_range(0, 1));
    b.spindle = 16'($urandom());
    b.has_spindle = ($urandom_range(0, 3) != 0);
    return b;
  endfunction

  // one command beat, with an occasional gap in front
  task automatic send_beat(cmd_beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, b.spindle, b.feed, b.val[2], b.val[1], b.val[0]};
    s_axis_tuser <= {b.has_spindle, b.has_feed, b.has[2], b.has[1], b.has[0], b.code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop offering commands until every action is out and the pipe is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (queued_actions.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (cfg_idx_t'(idx))
      CFG_X_MM:   k_mm[0] = v;
      CFG_Y_MM:   k_mm[1] = v;
      CFG_Z_MM:   k_mm[2] = v;
      CFG_X_INCH: k_inch[0] = v;
      CFG_Y_INCH: k_inch[1] = v;
      CFG_Z_INCH: k_inch[2] = v;
      CFG_RAPID:  rapid_feed = v[30:0];
      default: ;
    endcase
  endtask

  // all registers, then a write to the unused index
  task automatic configure(setup_style_t style);
    logic [31:0] v;
    for (int i = 0; i <= int'(CFG_RAPID); i++) begin
      case (style)
        SET_LOW:  v = (cfg_idx_t'(i) == CFG_RAPID) ? 32'd0 : 32'd1;
        SET_HIGH: v = 32'hffff_ffff;
        default:  v = $urandom_range(0, 1) ? $urandom() : $urandom_range(65536, 200000000);
      endcase
      write_reg(3'(i), v);
    end
    write_reg(CfgUnused, $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(int count, int hold_at, int pause_at);
    cmd_beat_t b;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_ask = 1'b1;
      if (i == pause_at) drain();
      b = random_command();
      send_beat(b);
      interpret_command(b);
      commit_plan();
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
    if (exp_v !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, got);
      mismatches++;
    end
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin : receiver
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result beat with the oldest queued action
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (queued_actions.size() == 0) begin
        $error("result beat with nothing queued: action %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want = queued_actions.pop_front();
        check_field("action", 32'(want.act), 32'(m_axis_tuser));
        check_field("step_x", want.step_x, m_axis_tdata[31:0]);
        check_field("step_y", want.step_y, m_axis_tdata[63:32]);
        check_field("step_z", want.step_z, m_axis_tdata[95:64]);
        check_field("feed_rate", want.rate, m_axis_tdata[127:96]);
        check_field("spindle_speed", 32'(want.spd), 32'(m_axis_tdata[143:128]));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_ask = 1'b0;
    // state after reset
    for (int a = 0; a < 3; a++) begin
      k_mm[a] = 32'd6553600;
      k_inch[a] = 32'd166461440;
      pos[a] = 0;
      work_off[a] = 0;
    end
    rapid_feed = 31'd6553600;
    abs_coords = 1'b1;
    inch_mode = 1'b0;
    current_feed = 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].b);
      interpret_command(directed_rows[i].b);
      if (directed_rows[i].typed) begin
        plan.delete();
        plan.push_back(beat_of(directed_rows[i].t_act, directed_rows[i].t_spd, 32'd0));
      end
      commit_plan();
    end

    // random phases over several register settings
    random_run(60, 10, -1);
    drain();
    configure(SET_RANDOM);
    random_run(60, -1, 30);
    drain();
    configure(SET_LOW);
    random_run(40, -1, -1);
    drain();
    configure(SET_HIGH);
    random_run(40, -1, -1);
    drain();
    configure(SET_RANDOM);
    calm = 1'b1;
    random_run(50, -1, -1);
    drain();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
